>>> rtl/anagram_window_matcher_top_defines.svh
// Assertion macros shared by the anagram window matcher checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ANAGRAM_WINDOW_MATCHER_TOP_DEFINES_SVH
`define ANAGRAM_WINDOW_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define AWM_ASSERT_SAME(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("awm assertion failed");

// Next-cycle implication, disabled while reset is low.
`define AWM_ASSERT_NEXT(name, ck, rn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("awm assertion failed");

`endif

>>> rtl/awm_pkg.sv
// Types and constants for the anagram window matcher.
// No dependencies; imported by the top level and its checker.
package awm_pkg;

  localparam int NUM_LETTERS = 26;
  localparam int MAX_PATTERN = 64;
  localparam int INDEX_BITS  = 20;

  localparam int LETTER_W = 5;
  localparam int ACTION_W = 2;
  localparam int LEN_W    = $clog2(MAX_PATTERN + 1);
  localparam int CNT_W    = LEN_W;
  localparam int RING_AW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  localparam logic [ACTION_W-1:0] ACT_BEGIN   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PATTERN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TEXT    = 2'd2;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LETTER_W-1:0] letter;
  } in_t;

  typedef struct packed {
    logic                  match;
    logic [INDEX_BITS-1:0] start_index;
  } out_t;

endpackage

>>> rtl/anagram_window_matcher_top.sv
// A text word waits in in_r until it proceeds; its result is then registered on out_word.
// One word per cycle unless a blocked result stalls input; 26-lane update and compare.
// The leaving letter comes from a 64-entry ring, prefetched into old_r ahead of its use.
// Reset clears counts, pattern length, ring pointer, text position and the
// pipeline valids; the ring contents are not cleared and need no clearing pass.
module anagram_window_matcher_top
  import awm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_word,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_word
);

  in_t                   in_r;
  logic                  in_v_r;
  out_t                  out_word_r;
  logic                  out_valid_r;

  cnt_t                  tgt_r   [NUM_LETTERS];
  cnt_t                  tgt_nxt [NUM_LETTERS];
  cnt_t                  win_r   [NUM_LETTERS];
  cnt_t                  win_nxt [NUM_LETTERS];
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [RING_AW-1:0]    ptr_r, ptr_nxt;
  logic [INDEX_BITS-1:0] pos_r, pos_nxt;

  logic [LETTER_W-1:0]   ring_mem [MAX_PATTERN];
  logic [LETTER_W-1:0]   old_r;
  logic                  wr_en;
  logic [RING_AW-1:0]    wr_addr;
  logic [RING_AW-1:0]    rd_addr;
  logic [LEN_W:0]        rd_sum;

  logic                  is_text, out_free, proceed;
  logic                  rm_en, dec, inc, cnt_eq;
  logic [INDEX_BITS:0]   pos_inc;
  logic [INDEX_BITS:0]   start_full;
  out_t                  res;

  assign is_text  = (in_r.action == ACT_TEXT);
  assign out_free = !out_valid_r || !out_stall;
  assign proceed  = in_v_r && (!is_text || out_free);
  assign in_stall = in_v_r && !proceed;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    tgt_nxt    = tgt_r;
    win_nxt    = win_r;
    len_nxt    = len_r;
    ptr_nxt    = ptr_r;
    pos_nxt    = pos_r;
    wr_en      = 1'b0;
    wr_addr    = ptr_r;
    rm_en      = 1'b0;
    dec        = 1'b0;
    inc        = 1'b0;
    cnt_eq     = 1'b1;
    pos_inc    = {1'b0, pos_r} + 1'b1;
    start_full = pos_inc - (INDEX_BITS+1)'(len_r);
    res        = '0;
    if (proceed) begin
      unique case (in_r.action)
        ACT_BEGIN: begin
          for (int i = 0; i < NUM_LETTERS; i++) begin
            tgt_nxt[i] = '0;
            win_nxt[i] = '0;
          end
          len_nxt = '0;
          ptr_nxt = '0;
          pos_nxt = '0;
        end
        ACT_PATTERN: begin
          // pattern words count only before the first text word
          if (pos_r == '0 && len_r < LEN_W'(MAX_PATTERN) &&
              in_r.letter < LETTER_W'(NUM_LETTERS)) begin
            tgt_nxt[in_r.letter] = tgt_r[in_r.letter] + 1'b1;
            len_nxt              = len_r + 1'b1;
          end
        end
        ACT_TEXT: begin
          rm_en = (len_r != '0) && ({1'b0, pos_r} >= (INDEX_BITS+1)'(len_r));
          for (int i = 0; i < NUM_LETTERS; i++) begin
            dec = rm_en && (old_r == LETTER_W'(i)) && (win_r[i] != '0);
            inc = (in_r.letter == LETTER_W'(i));
            win_nxt[i] = win_r[i] - cnt_t'(dec) + cnt_t'(inc);
          end
          for (int i = 0; i < NUM_LETTERS; i++) begin
            if (win_nxt[i] != tgt_r[i]) cnt_eq = 1'b0;
          end
          res.match = (len_r != '0) && (pos_inc >= (INDEX_BITS+1)'(len_r)) && cnt_eq;
          if (res.match) res.start_index = start_full[INDEX_BITS-1:0];
          wr_en   = 1'b1;
          ptr_nxt = (ptr_r == RING_AW'(MAX_PATTERN - 1)) ? '0 : ptr_r + 1'b1;
          pos_nxt = (pos_r == '1) ? pos_r : pos_r + 1'b1;
        end
        default: ;
      endcase
    end
    // slot that leaves the window on the next text word
    if ((LEN_W+1)'(ptr_nxt) >= (LEN_W+1)'(len_nxt)) begin
      rd_sum = (LEN_W+1)'(ptr_nxt) - (LEN_W+1)'(len_nxt);
    end else begin
      rd_sum = (LEN_W+1)'(ptr_nxt) + (LEN_W+1)'(MAX_PATTERN) - (LEN_W+1)'(len_nxt);
    end
    rd_addr = rd_sum[RING_AW-1:0];
  end

  // ring: write the text letter, prefetch the leaving letter with bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= in_r.letter;
    end
    if (wr_en && wr_addr == rd_addr) begin
      old_r <= in_r.letter;
    end else begin
      old_r <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      len_r       <= '0;
      ptr_r       <= '0;
      pos_r       <= '0;
      for (int i = 0; i < NUM_LETTERS; i++) begin
        tgt_r[i] <= '0;
        win_r[i] <= '0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        in_v_r <= 1'b1;
      end else if (proceed) begin
        in_v_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= proceed && is_text;
      end
      len_r <= len_nxt;
      ptr_r <= ptr_nxt;
      pos_r <= pos_nxt;
      tgt_r <= tgt_nxt;
      win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_word;
    end
    if (out_free) begin
      out_word_r <= res;
    end
  end

endmodule

>>> rtl/awm_checker.sv
// Port-level checker for the anagram window matcher, bound to the top level.
// Depends on awm_pkg and anagram_window_matcher_top_defines.svh.
`include "anagram_window_matcher_top_defines.svh"

module awm_checker
  import awm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_word,
  input logic out_valid,
  input logic out_stall,
  input out_t out_word
);

  // hold a stalled input word
  `AWM_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && in_stall, in_valid && $stable(in_word))
  // hold a stalled result word
  `AWM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))
  // input backs up only behind a blocked result
  `AWM_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  // no start index without a match
  `AWM_ASSERT_SAME(a_start_zero, clk, rst_n, out_valid && !out_word.match, out_word.start_index == '0)

endmodule

bind anagram_window_matcher_top awm_checker u_awm_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for the sliding-window anagram matcher.
// Depends on awm_pkg and anagram_window_matcher_top; predicts every text word's
// verdict in-line and checks it against the result channel under random idling.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import awm_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 950;
  localparam int PRINT_CAP = 40;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef letter_t letters_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_word;

  // search state mirrored from the block
  cnt_t want_cnt [NUM_LETTERS];
  cnt_t win_cnt [NUM_LETTERS];
  logic [LEN_W-1:0] pat_len = '0;
  letter_t ring [MAX_PATTERN];
  logic [RING_AW-1:0] ring_wr = '0;
  logic [INDEX_BITS-1:0] text_pos = '0;

  out_t window_verdicts[$];
  int errors = 0;
  int words_sent = 0;
  bit idle_en = 1'b1;
  int unsigned stall_left = 0;

  anagram_window_matcher_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  always #1 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic in_t word_of(input logic [ACTION_W-1:0] act, input int unsigned l);
    in_t w;
    w.action = act;
    w.letter = l[LETTER_W-1:0];
    return w;
  endfunction

  task automatic report(input string what);
    errors++;
    if (errors <= PRINT_CAP) $display("%0t: %s", $time, what);
  endtask

  task automatic clear_search();
    foreach (want_cnt[i]) begin
      want_cnt[i] = '0;
      win_cnt[i] = '0;
    end
    pat_len = '0;
    ring_wr = '0;
    text_pos = '0;
  endtask

  // Update the mirrored state for one accepted word and queue its verdict.
  task automatic slide_window(input in_t w);
    logic [RING_AW-1:0] slot;
    letter_t old;
    bit same;
    out_t v;
    case (w.action)
      ACT_BEGIN: clear_search();
      ACT_PATTERN: begin
        if (text_pos == 0 && pat_len < MAX_PATTERN && w.letter < NUM_LETTERS) begin
          want_cnt[w.letter]++;
          pat_len++;
        end
      end
      ACT_TEXT: begin
        // drop the letter that leaves the window
        if (pat_len != 0 && text_pos >= pat_len) begin
          slot = ring_wr - pat_len[RING_AW-1:0];
          old = ring[slot];
          if (old < NUM_LETTERS && win_cnt[old] != 0) win_cnt[old]--;
        end
        if (w.letter < NUM_LETTERS) win_cnt[w.letter]++;
        ring[ring_wr] = w.letter;
        ring_wr++;
        same = 1'b1;
        foreach (want_cnt[i]) if (want_cnt[i] != win_cnt[i]) same = 1'b0;
        v.match = (pat_len != 0) && (text_pos + 1 >= pat_len) && same;
        v.start_index = v.match ? INDEX_BITS'(text_pos + 1 - pat_len) : '0;
        if (text_pos != '1) text_pos++;
        window_verdicts.insert(window_verdicts.size(), v);
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input in_t w);
    int gap;
    bit stalled;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    forever begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
    end
    slide_window(w);
    if (w.action != ACT_UNUSED) words_sent++;
  endtask

  task automatic send_shuffled(input letters_t q);
    int j;
    letter_t t;
    for (int i = q.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = q[i];
      q[i] = q[j];
      q[j] = t;
    end
    foreach (q[i]) send_word(word_of(ACT_TEXT, q[i]));
  endtask

  // Begin a search and load a pattern; returns the letters the block keeps.
  task automatic load_pattern(input int plen, input int alpha, output letters_t kept);
    int unsigned l;
    kept.delete();
    send_word(word_of(ACT_BEGIN, $urandom_range(0, 31)));
    repeat (plen) begin
      l = $urandom_range(0, alpha - 1);
      if ($urandom_range(0, 29) == 0) l = $urandom_range(26, 31);
      if (l < NUM_LETTERS && kept.size() < MAX_PATTERN) kept.insert(kept.size(), letter_t'(l));
      send_word(word_of(ACT_PATTERN, l));
    end
  endtask

  task automatic test_directed();
    send_word(word_of(ACT_BEGIN, 31));
    send_word(word_of(ACT_TEXT, 0));         // empty pattern: never a hit
    send_word(word_of(ACT_BEGIN, 0));
    send_word(word_of(ACT_PATTERN, 0));
    send_word(word_of(ACT_PATTERN, 25));
    send_word(word_of(ACT_PATTERN, 26));     // out of range, ignored
    send_word(word_of(ACT_PATTERN, 31));
    send_word(word_of(ACT_UNUSED, 5));
    send_word(word_of(ACT_TEXT, 25));
    send_word(word_of(ACT_TEXT, 0));
    send_word(word_of(ACT_PATTERN, 2));      // pattern after text, ignored
    send_word(word_of(ACT_TEXT, 25));
    send_word(word_of(ACT_TEXT, 31));        // takes a slot, counts as no letter
    send_word(word_of(ACT_TEXT, 0));
    send_word(word_of(ACT_TEXT, 25));
    send_word(word_of(ACT_UNUSED, 31));
    send_word(word_of(ACT_BEGIN, 31));
  endtask

  // Overlong pattern: only the first MAX_PATTERN letters count.
  task automatic test_long_pattern();
    letters_t kept;
    load_pattern(MAX_PATTERN + 2, 4, kept);
    send_shuffled(kept);
    repeat (80) send_word(word_of(ACT_TEXT, $urandom_range(0, 3)));
    send_shuffled(kept);
  endtask

  task automatic test_random();
    letters_t kept;
    int base;
    int alpha;
    int plen;
    int unsigned l;
    base = words_sent;
    while (words_sent < base + RANDOM_WORDS) begin
      idle_en = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8))
          send_word(word_of(ACTION_W'($urandom_range(0, 3)), $urandom_range(0, 31)));
      end else begin
        alpha = ($urandom_range(0, 3) == 0) ? NUM_LETTERS : $urandom_range(1, 4);
        case ($urandom_range(0, 19))
          0: plen = 0;
          1: plen = $urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 6);
          default: plen = $urandom_range(1, 8);
        endcase
        load_pattern(plen, alpha, kept);
        repeat ($urandom_range(2, 5)) begin
          if ($urandom_range(0, 2) == 0) send_shuffled(kept);
          else begin
            repeat ($urandom_range(1, 2 * plen + 4)) begin
              l = $urandom_range(0, alpha - 1);
              if ($urandom_range(0, 39) == 0) l = $urandom_range(26, 31);
              if ($urandom_range(0, 29) == 0) send_word(word_of(ACT_PATTERN, l));
              else send_word(word_of(ACT_TEXT, l));
            end
          end
        end
      end
    end
    idle_en = 1'b1;
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_en && $urandom_range(0, 4) == 0) stall_left = gap_len();
    out_stall <= (stall_left > 0);
  end

  // Values at the falling edge are the ones the next rising edge accepts.
  always @(negedge clk) begin
    out_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (window_verdicts.size() == 0) begin
        report("result word with no verdict pending");
      end else begin
        want = window_verdicts.pop_front();
        if (out_word.match !== want.match)
          report($sformatf("match got %b want %b", out_word.match, want.match));
        if (out_word.start_index !== want.start_index)
          report($sformatf("start_index got %0d want %0d",
                           out_word.start_index, want.start_index));
      end
    end
  end

  initial begin
    clear_search();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_pattern();
    test_random();
    in_valid <= 1'b0;
    while (window_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
